// ===== design/lzwp_pkg.sv =====
`default_nettype none

package lzwp_pkg;

   // Code widths and derived sizes.
   localparam int MAX_CODE_WIDTH = 15;
   localparam int MIN_CODE_WIDTH = 9;
   localparam int CODE_W         = 15;
   localparam int CNT_W          = 15;
   localparam int BYTE_W         = 8;
   localparam int ACC_W          = MAX_CODE_WIDTH + BYTE_W - 1;
   localparam int HOLD_W         = $clog2(ACC_W + 1);
   localparam int WIDTH_W        = $clog2(MAX_CODE_WIDTH + 1);

   // Queue between the front and the back.
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCOUNT_W = $clog2(QDEPTH + 1);

   // Command codes and fixed code values.
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [CNT_W-1:0]  CODE_COUNTER_RESET = CNT_W'(256);
   localparam logic [CNT_W-1:0]  CODE_COUNTER_MAX   = CNT_W'(32767);
   localparam logic [CODE_W-1:0] END_CODE           = CODE_W'(256);

   typedef struct packed {
      logic              command;
      logic [CODE_W-1:0] code_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_of_run;
   } rsp_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic               restart;
      logic               end_code;
      logic [WIDTH_W-1:0] width;
      logic [CODE_W-1:0]  code;
   } entry_type;

   // Width of the next code, taken from the counter before it steps.
   function automatic logic [WIDTH_W-1:0] width_for(logic [CNT_W-1:0] counter);
      logic [WIDTH_W-1:0] w;
      w = WIDTH_W'(MIN_CODE_WIDTH);
      for (int i = MIN_CODE_WIDTH; i < MAX_CODE_WIDTH; i++) begin
         if (32'(counter) > ((32'd1 << i) - 32'd1)) begin
            w = WIDTH_W'(i + 1);
         end
      end
      return w;
   endfunction

   // Mask that keeps the low bits of a code that fit the given width.
   function automatic logic [CODE_W-1:0] code_mask(logic [WIDTH_W-1:0] w);
      logic [CODE_W:0] m;
      m = ({{CODE_W{1'b0}}, 1'b1} << w) - {{CODE_W{1'b0}}, 1'b1};
      return m[CODE_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/lzwp_front.sv =====
`default_nettype none

module lzwp_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  lzwp_pkg::req_type       req_data,
   input  wire                     q_full,
   output logic                    q_push,
   output lzwp_pkg::entry_type     q_entry
);
   import lzwp_pkg::*;

   logic [CNT_W-1:0]   counter_ff;
   logic [CNT_W-1:0]   counter_in;
   logic [WIDTH_W-1:0] width;
   logic               restart;

   // A transfer happens whenever a request is valid and the queue has room.
   assign q_push  = req_valid && !q_full;
   assign restart = (req_data.command == CMD_RESTART);
   assign width   = width_for(counter_ff);

   // Classify the item and cut the code to the current width.
   always_comb begin
      q_entry.restart  = restart;
      q_entry.end_code = (req_data.code_value == END_CODE);
      q_entry.width    = width;
      q_entry.code     = req_data.code_value & code_mask(width);
   end

   // The code counter steps once per written code and saturates; a restart sets it back to 256.
   always_comb begin
      counter_in = counter_ff;
      if (q_push) begin
         if (restart) begin
            counter_in = CODE_COUNTER_RESET;
         end else if (counter_ff < CODE_COUNTER_MAX) begin
            counter_in = counter_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= CODE_COUNTER_RESET;
      end else begin
         counter_ff <= counter_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lzwp_queue.sv =====
`default_nettype none

module lzwp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  lzwp_pkg::entry_type  push_entry,
   output logic                 full,
   input  wire                  pop,
   output logic                 pop_valid,
   output lzwp_pkg::entry_type  pop_entry
);
   import lzwp_pkg::*;

   entry_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCOUNT_W-1:0]  count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == QCOUNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers wrap at the queue depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCOUNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCOUNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/lzwp_back.sv =====
`default_nettype none

module lzwp_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   input  lzwp_pkg::entry_type  q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lzwp_pkg::rsp_type    rsp_data
);
   import lzwp_pkg::*;

   typedef enum logic {
      BK_IDLE,
      BK_EMIT
   } state_type;

   state_type          state_ff,     state_in;
   logic [ACC_W-1:0]   acc_ff,       acc_in;
   logic [HOLD_W-1:0]  hold_ff,      hold_in;
   logic               end_ff,       end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;
   logic               out_free;
   logic [HOLD_W-1:0]  remain;
   logic               last;

   localparam logic [HOLD_W-1:0] BYTE_BITS = HOLD_W'(BYTE_W);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign remain    = hold_ff - BYTE_BITS;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A full byte is the last one unless another full byte or a flush follows.
   assign last = (remain < BYTE_BITS) && !(end_ff && (remain != '0));

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      hold_in      = hold_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            // Take the next item and merge its code above the held bits; a restart clears them instead.
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.restart) begin
                  acc_in  = '0;
                  hold_in = '0;
               end else begin
                  acc_in   = acc_ff | (ACC_W'(q_entry.code) << hold_ff);
                  hold_in  = hold_ff + HOLD_W'(q_entry.width);
                  end_in   = q_entry.end_code;
                  state_in = BK_EMIT;
               end
            end
         end
         BK_EMIT: begin
            if (hold_ff >= BYTE_BITS) begin
               // Emit one whole byte when the output register is free.
               if (out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.out_byte     = acc_ff[BYTE_W-1:0];
                  rsp_data_in.last_of_run  = last;
                  acc_in  = acc_ff >> BYTE_W;
                  hold_in = remain;
                  if (last) begin
                     state_in = BK_IDLE;
                     if (end_ff) begin
                        acc_in  = '0;
                        hold_in = '0;
                     end
                  end
               end
            end else if (end_ff && (hold_ff != '0)) begin
               // Flush the zero-padded partial byte at the end of the stream.
               if (out_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.out_byte    = acc_ff[BYTE_W-1:0];
                  rsp_data_in.last_of_run = 1'b1;
                  acc_in   = '0;
                  hold_in  = '0;
                  state_in = BK_IDLE;
               end
            end else begin
               // The code caused no byte.
               if (end_ff) begin
                  acc_in  = '0;
                  hold_in = '0;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         acc_ff       <= '0;
         hold_ff      <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         hold_ff      <= hold_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/lzw_variable_width_code_packer_top.sv =====
// LZW variable-width code packer.
//
// Input channel (req_): one transfer carries a command and a code. A write
// command packs the code at the current width (9 to 15 bits, growing with
// the code count); the end code also flushes a zero-padded partial byte.
// A restart clears the held bits, resets the code counter and emits nothing.
// Result channel (rsp_): one transfer carries one packed byte, least
// significant bits first; last_of_run marks the final byte of each code.
//
// Flow: a transferred code is written into the queue. The back end pops it
// while idle, merges it above the held bits in the accumulator, and then
// loads its bytes one at a time into the byte register, waiting while the
// receiver stalls; a code that yields no byte still passes through the emit
// state. A two-entry queue lets new items in while the back end works.
// Reset clears the accumulator, bit count and queue and sets the code
// counter to 256. When the receiver stalls, the byte register holds its value
// and the back end waits; once the queue fills, req_stall rises.
`default_nettype none

module lzw_variable_width_code_packer_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  lzwp_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output lzwp_pkg::rsp_type  rsp_data
);
   import lzwp_pkg::*;

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   logic      q_valid;
   entry_type q_pop_entry;

   assign req_stall = q_full;

   lzwp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_entry)
   );

   lzwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_pop_entry)
   );

   lzwp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_pop_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/lzwp_checker.sv =====
`default_nettype none

module lzwp_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_stall,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input lzwp_pkg::rsp_type  rsp_data
);
   import lzwp_pkg::*;

   // A stalled byte stays in place until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Reset leaves no byte pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Reset empties the queue, so the input side is open.
   a_reset_open: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled after reset");

   // A byte that is not the last of its run is followed at once by the next.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=> rsp_valid)
      else $error("run of bytes broken");

endmodule

bind lzw_variable_width_code_packer_top lzwp_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
